/* hw/rtl/pwbs_pkg.sv */
`timescale 1ns / 1ps
package pwbs_pkg;
  localparam int MAX_DIM_DEF   = 4096;
  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int DIM_W      = 13;
  localparam int COORD_W    = 32;
  localparam int INDEX_W    = 24;
  localparam int WEIGHT_W   = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_R0_C01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_R0_C23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_R1_C01 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_R1_C23 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_R2_C01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_R2_C23 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd7;

  localparam logic [CFG_DATA_W-1:0] RST_R0_C01 = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_W-1:0] RST_R0_C23 = 64'h0;
  localparam logic [CFG_DATA_W-1:0] RST_R1_C01 = 64'h0001_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_R1_C23 = 64'h0;
  localparam logic [CFG_DATA_W-1:0] RST_R2_C01 = 64'h0;
  localparam logic [CFG_DATA_W-1:0] RST_R2_C23 = 64'h0000_0000_0001_0000;
  localparam logic [DIM_W-1:0]      RST_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]      RST_HEIGHT = 13'd480;
endpackage

/* hw/rtl/pwbs_if.sv */
`timescale 1ns / 1ps
interface pwbs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pwbs_pkg::COORD_W-1:0] point_x;
  logic signed [pwbs_pkg::COORD_W-1:0] point_y;
  logic signed [pwbs_pkg::COORD_W-1:0] point_z;
  logic                                last_point;
  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface pwbs_out_if;
  logic                              valid;
  logic                              ready;
  logic [pwbs_pkg::INDEX_W-1:0]      pixel_index;
  logic                              in_bounds;
  logic [pwbs_pkg::WEIGHT_W-1:0]     weight_00;
  logic [pwbs_pkg::WEIGHT_W-1:0]     weight_10;
  logic [pwbs_pkg::WEIGHT_W-1:0]     weight_01;
  logic [pwbs_pkg::WEIGHT_W-1:0]     weight_11;
  logic                              last_out;
  modport source (output valid, pixel_index, in_bounds, weight_00, weight_10, weight_01,
                  weight_11, last_out, input ready);
  modport sink (input valid, pixel_index, in_bounds, weight_00, weight_10, weight_01,
                weight_11, last_out, output ready);
endinterface

/* hw/rtl/pwbs_front.sv */
`timescale 1ns / 1ps
module pwbs_front #(
  parameter int MAX_DIM   = pwbs_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = pwbs_pkg::FRAC_BITS_DEF,
  localparam int UW = 66 - FRAC_BITS,
  localparam int IB = $clog2(MAX_DIM),
  localparam int PW = 3 * UW + 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [pwbs_pkg::COORD_W-1:0] x,
  input  logic signed [pwbs_pkg::COORD_W-1:0] y,
  input  logic signed [pwbs_pkg::COORD_W-1:0] z,
  input  logic                                last,
  input  logic [pwbs_pkg::CFG_DATA_W-1:0]     mat_c01 [3],
  input  logic [pwbs_pkg::CFG_DATA_W-1:0]     mat_c23 [3],
  input  logic                                q_full,
  output logic                                q_push,
  output logic [PW-1:0]                       q_data
);
  logic               en;
  logic               a_v_r, b_v_r, c_v_r, d_v_r;
  logic               a_last_r, b_last_r, c_last_r, d_last_r;
  logic signed [63:0] a_p_r [3][3];
  logic signed [31:0] a_t_r [3];
  logic signed [UW-1:0] b_s_r [3];
  logic signed [UW-1:0] b_s_nxt [3];
  logic [UW-1:0]      c_u_r [3];
  logic               c_ok_r;
  logic [UW-1:0]      d_u_r [3];
  logic               d_ok_r;

  assign en       = !d_v_r || !q_full;
  assign in_ready = en;
  assign q_push   = d_v_r && !q_full;
  assign q_data   = {d_ok_r, d_last_r, d_u_r[2], d_u_r[1], d_u_r[0]};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      b_s_nxt[r] = UW'(a_p_r[r][0] >>> FRAC_BITS) + UW'(a_p_r[r][1] >>> FRAC_BITS)
                 + UW'(a_p_r[r][2] >>> FRAC_BITS) + UW'(a_t_r[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        a_p_r[r][0] <= signed'(mat_c01[r][31:0]) * x;
        a_p_r[r][1] <= signed'(mat_c01[r][63:32]) * y;
        a_p_r[r][2] <= signed'(mat_c23[r][31:0]) * z;
        a_t_r[r]    <= signed'(mat_c23[r][63:32]);
        b_s_r[r]    <= b_s_nxt[r];
        c_u_r[r]    <= b_s_r[r][UW-1] ? UW'(-b_s_r[r]) : UW'(b_s_r[r]);
        d_u_r[r]    <= c_u_r[r];
      end
      a_last_r <= last;
      b_last_r <= a_last_r;
      c_last_r <= b_last_r;
      d_last_r <= c_last_r;
      c_ok_r   <= (b_s_r[2] != '0)
                  && ((b_s_r[0] == '0) || (b_s_r[0][UW-1] == b_s_r[2][UW-1]))
                  && ((b_s_r[1] == '0) || (b_s_r[1][UW-1] == b_s_r[2][UW-1]));
      d_ok_r   <= c_ok_r && ((c_u_r[0] >> IB) < c_u_r[2]) && ((c_u_r[1] >> IB) < c_u_r[2]);
    end
  end
endmodule

/* hw/rtl/pwbs_queue.sv */
`timescale 1ns / 1ps
module pwbs_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] pop_data
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign pop_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end
endmodule

/* hw/rtl/pwbs_back.sv */
`timescale 1ns / 1ps
module pwbs_back #(
  parameter int MAX_DIM   = pwbs_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = pwbs_pkg::FRAC_BITS_DEF,
  localparam int UW = 66 - FRAC_BITS,
  localparam int IB = $clog2(MAX_DIM),
  localparam int QB = IB + FRAC_BITS,
  localparam int DW = $clog2(MAX_DIM + 1),
  localparam int PW = 3 * UW + 2,
  localparam int WW = FRAC_BITS + 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_not_empty,
  input  logic [PW-1:0] q_data,
  output logic          q_pop,
  input  logic [DW-1:0] wd,
  input  logic [DW-1:0] hd,
  pwbs_out_if.source    out_ch
);
  logic en;
  logic            v_r    [QB+1];
  logic            ok_r   [QB+1];
  logic            last_r [QB+1];
  logic [UW-1:0]   ud_r   [QB+1];
  logic [UW-1:0]   r0_r   [QB+1];
  logic [UW-1:0]   r1_r   [QB+1];
  logic [QB-1:0]   n0_r   [QB+1];
  logic [QB-1:0]   n1_r   [QB+1];
  logic [QB-1:0]   q0_r   [QB+1];
  logic [QB-1:0]   q1_r   [QB+1];
  logic [UW-1:0]   un0, un1, ud;

  logic                 m_v_r, m_ok_r, m_last_r;
  logic [2*FRAC_BITS-1:0] m_prod_r;
  logic [IB+DW-1:0]     m_idx_r;
  logic [IB-1:0]        m_col_r;
  logic [FRAC_BITS-1:0] m_fx_r, m_fy_r;
  logic [IB-1:0]        col, row;

  logic                 o_v_r;
  logic [WW-1:0]        w11;
  logic [WW-1:0]        one;

  assign en    = !o_v_r || out_ch.ready;
  assign q_pop = en && q_not_empty;
  assign {un1, un0} = q_data[2*UW-1:0];
  assign ud    = q_data[3*UW-1:2*UW];
  assign col   = q0_r[QB][QB-1:FRAC_BITS];
  assign row   = q1_r[QB][QB-1:FRAC_BITS];
  assign one   = WW'(1) << FRAC_BITS;
  assign w11   = WW'((m_prod_r + (2*FRAC_BITS)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_r[0]   <= q_data[PW-1];
      last_r[0] <= q_data[PW-2];
      ud_r[0]   <= ud;
      r0_r[0]   <= un0 >> IB;
      r1_r[0]   <= un1 >> IB;
      n0_r[0]   <= {un0[IB-1:0], {FRAC_BITS{1'b0}}};
      n1_r[0]   <= {un1[IB-1:0], {FRAC_BITS{1'b0}}};
      q0_r[0]   <= '0;
      q1_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [UW:0] t0, t1;
    logic        ge0, ge1;
    logic [UW:0] d0, d1;
    always_comb begin
      t0  = {r0_r[k], n0_r[k][QB-1]};
      t1  = {r1_r[k], n1_r[k][QB-1]};
      ge0 = t0 >= {1'b0, ud_r[k]};
      ge1 = t1 >= {1'b0, ud_r[k]};
      d0  = t0 - {1'b0, ud_r[k]};
      d1  = t1 - {1'b0, ud_r[k]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ok_r[k+1]   <= ok_r[k];
        last_r[k+1] <= last_r[k];
        ud_r[k+1]   <= ud_r[k];
        r0_r[k+1]   <= ge0 ? d0[UW-1:0] : t0[UW-1:0];
        r1_r[k+1]   <= ge1 ? d1[UW-1:0] : t1[UW-1:0];
        n0_r[k+1]   <= n0_r[k] << 1;
        n1_r[k+1]   <= n1_r[k] << 1;
        q0_r[k+1]   <= {q0_r[k][QB-2:0], ge0};
        q1_r[k+1]   <= {q1_r[k][QB-2:0], ge1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= v_r[QB];
      o_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_ok_r   <= ok_r[QB] && (32'(col) + 32'd1 < 32'(wd)) && (32'(row) + 32'd1 < 32'(hd));
      m_last_r <= last_r[QB];
      m_prod_r <= q0_r[QB][FRAC_BITS-1:0] * q1_r[QB][FRAC_BITS-1:0];
      m_idx_r  <= row * wd;
      m_col_r  <= col;
      m_fx_r   <= q0_r[QB][FRAC_BITS-1:0];
      m_fy_r   <= q1_r[QB][FRAC_BITS-1:0];
      out_ch.last_out    <= m_last_r;
      out_ch.in_bounds   <= m_ok_r;
      if (m_ok_r) begin
        out_ch.pixel_index <= pwbs_pkg::INDEX_W'(m_idx_r + (IB+DW)'(m_col_r));
        out_ch.weight_00   <= pwbs_pkg::WEIGHT_W'(one - WW'(m_fx_r) - WW'(m_fy_r) + w11);
        out_ch.weight_10   <= pwbs_pkg::WEIGHT_W'(WW'(m_fx_r) - w11);
        out_ch.weight_01   <= pwbs_pkg::WEIGHT_W'(WW'(m_fy_r) - w11);
        out_ch.weight_11   <= pwbs_pkg::WEIGHT_W'(w11);
      end else begin
        out_ch.pixel_index <= '0;
        out_ch.weight_00   <= '0;
        out_ch.weight_10   <= '0;
        out_ch.weight_01   <= '0;
        out_ch.weight_11   <= '0;
      end
    end
  end

  assign out_ch.valid = o_v_r;
endmodule

/* hw/rtl/perspective_warp_bilinear_setup_top.sv */
`timescale 1ns / 1ps
// pipeline: 4 front stages, the queue, then 1 + (log2(MAX_DIM) + FRAC_BITS) divider
// stages and 2 weight stages
// throughput: one item per cycle while the receiver holds ready high, set by the bit-per-stage pipelined divider
// a 2-entry queue parts the front and the back so each side stalls on its own
// reset (synchronous, rst_n low): pipeline emptied, matrix identity, 640 x 480 image
module perspective_warp_bilinear_setup_top #(
  parameter int MAX_DIM   = pwbs_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = pwbs_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  pwbs_in_if.sink                             in_ch,
  pwbs_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [pwbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pwbs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  localparam int UW = 66 - FRAC_BITS;
  localparam int PW = 3 * UW + 2;
  localparam int DW = $clog2(MAX_DIM + 1);

  logic [pwbs_pkg::CFG_DATA_W-1:0] mat_c01_r [3];
  logic [pwbs_pkg::CFG_DATA_W-1:0] mat_c23_r [3];
  logic [pwbs_pkg::DIM_W-1:0]      width_r, height_r;
  logic [DW-1:0]                   wd, hd;
  logic                            q_full, q_push, q_pop, q_not_empty;
  logic [PW-1:0]                   q_wdata, q_rdata;

  assign wd = (32'(width_r) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(width_r);
  assign hd = (32'(height_r) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(height_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_c01_r[0] <= pwbs_pkg::RST_R0_C01;
      mat_c23_r[0] <= pwbs_pkg::RST_R0_C23;
      mat_c01_r[1] <= pwbs_pkg::RST_R1_C01;
      mat_c23_r[1] <= pwbs_pkg::RST_R1_C23;
      mat_c01_r[2] <= pwbs_pkg::RST_R2_C01;
      mat_c23_r[2] <= pwbs_pkg::RST_R2_C23;
      width_r      <= pwbs_pkg::RST_WIDTH;
      height_r     <= pwbs_pkg::RST_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        pwbs_pkg::CFG_R0_C01: mat_c01_r[0] <= cfg_data;
        pwbs_pkg::CFG_R0_C23: mat_c23_r[0] <= cfg_data;
        pwbs_pkg::CFG_R1_C01: mat_c01_r[1] <= cfg_data;
        pwbs_pkg::CFG_R1_C23: mat_c23_r[1] <= cfg_data;
        pwbs_pkg::CFG_R2_C01: mat_c01_r[2] <= cfg_data;
        pwbs_pkg::CFG_R2_C23: mat_c23_r[2] <= cfg_data;
        pwbs_pkg::CFG_WIDTH:  width_r      <= cfg_data[pwbs_pkg::DIM_W-1:0];
        pwbs_pkg::CFG_HEIGHT: height_r     <= cfg_data[pwbs_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  pwbs_front #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .x        (in_ch.point_x),
    .y        (in_ch.point_y),
    .z        (in_ch.point_z),
    .last     (in_ch.last_point),
    .mat_c01  (mat_c01_r),
    .mat_c23  (mat_c23_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  pwbs_queue #(.W(PW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_rdata)
  );

  pwbs_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .wd          (wd),
    .hd          (hd),
    .out_ch      (out_ch)
  );
endmodule

/* bench/tb_perspective_warp_bilinear_setup_top.sv */
`timescale 1ns / 1ps

typedef struct {
  logic [pwbs_pkg::INDEX_W-1:0]  pixel_index;
  logic                          in_bounds;
  logic [pwbs_pkg::WEIGHT_W-1:0] w00, w10, w01, w11;
  logic                          last_out;
} warp_result_t;

class warp_scoreboard;
  logic [63:0] mat [6];
  logic [12:0] img_w, img_h;
  warp_result_t pending[$];
  int errors;

  function new();
    mat[0] = pwbs_pkg::RST_R0_C01; mat[1] = pwbs_pkg::RST_R0_C23;
    mat[2] = pwbs_pkg::RST_R1_C01; mat[3] = pwbs_pkg::RST_R1_C23;
    mat[4] = pwbs_pkg::RST_R2_C01; mat[5] = pwbs_pkg::RST_R2_C23;
    img_w = pwbs_pkg::RST_WIDTH; img_h = pwbs_pkg::RST_HEIGHT;
    errors = 0;
  endfunction

  function void set_reg(logic [pwbs_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    if (idx == pwbs_pkg::CFG_WIDTH) img_w = val[12:0];
    else if (idx == pwbs_pkg::CFG_HEIGHT) img_h = val[12:0];
    else mat[idx] = val;
  endfunction

  // arithmetic shift of a signed 64-bit product is the floor
  function automatic longint fix_mul(logic [31:0] c, logic [31:0] v);
    longint p;
    p = longint'($signed(c)) * longint'($signed(v));
    return p >>> pwbs_pkg::FRAC_BITS_DEF;
  endfunction

  function automatic longint project_row(int r, logic [31:0] x, logic [31:0] y,
                                         logic [31:0] z);
    return fix_mul(mat[2*r][31:0], x) + fix_mul(mat[2*r][63:32], y)
         + fix_mul(mat[2*r+1][31:0], z) + longint'($signed(mat[2*r+1][63:32]));
  endfunction

  function automatic bit floor_div(longint num, longint den, output longint ip,
                                   output longint fp);
    longint un, ud, r;
    ip = 0; fp = 0;
    if (den == 0) return 0;
    if (num != 0 && ((num < 0) != (den < 0))) return 0;
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    ip = un / ud;
    r = un % ud;
    for (int i = 0; i < pwbs_pkg::FRAC_BITS_DEF; i++) begin
      r = r << 1;
      fp = fp << 1;
      if (r >= ud) begin
        r = r - ud;
        fp = fp | 1;
      end
    end
    return 1;
  endfunction

  function void note_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
    longint s0, s1, s2, col, row, fx, fy, w, h, w11;
    bit ok_c, ok_r;
    warp_result_t e;
    s0 = project_row(0, x, y, z);
    s1 = project_row(1, x, y, z);
    s2 = project_row(2, x, y, z);
    w = img_w > pwbs_pkg::MAX_DIM_DEF ? pwbs_pkg::MAX_DIM_DEF : img_w;
    h = img_h > pwbs_pkg::MAX_DIM_DEF ? pwbs_pkg::MAX_DIM_DEF : img_h;
    ok_c = floor_div(s0, s2, col, fx);
    ok_r = floor_div(s1, s2, row, fy);
    e = '{pixel_index: '0, in_bounds: 0, w00: '0, w10: '0, w01: '0, w11: '0,
          last_out: last};
    if (ok_c && ok_r && col + 1 < w && row + 1 < h) begin
      w11 = (fx * fy + (1 << (pwbs_pkg::FRAC_BITS_DEF - 1))) >> pwbs_pkg::FRAC_BITS_DEF;
      e.pixel_index = pwbs_pkg::INDEX_W'(row * w + col);
      e.in_bounds = 1;
      e.w00 = pwbs_pkg::WEIGHT_W'((1 << pwbs_pkg::FRAC_BITS_DEF) - fx - fy + w11);
      e.w10 = pwbs_pkg::WEIGHT_W'(fx - w11);
      e.w01 = pwbs_pkg::WEIGHT_W'(fy - w11);
      e.w11 = pwbs_pkg::WEIGHT_W'(w11);
    end
    pending.push_back(e);
  endfunction

  function void check_result(warp_result_t a);
    warp_result_t e;
    if (pending.size() == 0) begin
      $error("unexpected result item");
      errors++;
      return;
    end
    e = pending.pop_front();
    if (a.pixel_index !== e.pixel_index) begin
      $error("pixel_index exp %0d got %0d", e.pixel_index, a.pixel_index); errors++;
    end
    if (a.in_bounds !== e.in_bounds) begin
      $error("in_bounds exp %0d got %0d", e.in_bounds, a.in_bounds); errors++;
    end
    if (a.w00 !== e.w00) begin
      $error("weight_00 exp %0d got %0d", e.w00, a.w00); errors++;
    end
    if (a.w10 !== e.w10) begin
      $error("weight_10 exp %0d got %0d", e.w10, a.w10); errors++;
    end
    if (a.w01 !== e.w01) begin
      $error("weight_01 exp %0d got %0d", e.w01, a.w01); errors++;
    end
    if (a.w11 !== e.w11) begin
      $error("weight_11 exp %0d got %0d", e.w11, a.w11); errors++;
    end
    if (a.last_out !== e.last_out) begin
      $error("last_out exp %0d got %0d", e.last_out, a.last_out); errors++;
    end
  endfunction
endclass

module tb_perspective_warp_bilinear_setup_top;
  localparam int LIMIT = 400000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [pwbs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pwbs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int cycles = 0;
  bit stim_done = 0;
  int burst_left = 0, gap_left = 0;

  pwbs_in_if in_ch();
  pwbs_out_if out_ch();
  warp_scoreboard sb = new();

  perspective_warp_bilinear_setup_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    in_ch.last_point = 0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stall pattern: phases of full speed, random and heavy stall
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 0;
    else case ((cycles / 300) % 3)
      0: out_ch.ready <= 1;
      1: out_ch.ready <= ($urandom_range(3) != 0);
      default: out_ch.ready <= ($urandom_range(3) == 0);
    endcase
  end

  always @(posedge clk) begin
    warp_result_t a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a.pixel_index = out_ch.pixel_index;
      a.in_bounds = out_ch.in_bounds;
      a.w00 = out_ch.weight_00;
      a.w10 = out_ch.weight_10;
      a.w01 = out_ch.weight_01;
      a.w11 = out_ch.weight_11;
      a.last_out = out_ch.last_out;
      sb.check_result(a);
    end
  end

  task automatic write_reg(logic [pwbs_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
    // sender bursts and gaps
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(0, 6);
    end
    while (gap_left > 0) begin
      in_ch.valid <= 0;
      gap_left--;
      @(posedge clk);
    end
    burst_left--;
    in_ch.valid <= 1;
    in_ch.point_x <= x;
    in_ch.point_y <= y;
    in_ch.point_z <= z;
    in_ch.last_point <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_point(x, y, z, last);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] q16(int v);
    return 32'(v) << 16;
  endfunction

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return q16($urandom_range(0, 700)) | $urandom_range(0, 65535);
      default: return q16($urandom_range(0, 6)) - 32'(3 << 16) + $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic random_points(int n, int mode);
    repeat (n) send_point(rand_coord(mode), rand_coord(mode),
                          ($urandom_range(7) == 0) ? rand_coord(0) :
                          q16($urandom_range(1, 3)) | $urandom_range(0, 65535),
                          1'($urandom_range(1)));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed, reset identity matrix
    send_point(q16(0), q16(0), q16(1), 0);
    send_point(q16(638) | 32'hFFFF, q16(478) | 32'hFFFF, q16(1), 0);
    send_point(q16(639), q16(10), q16(1), 0);
    send_point(q16(10), q16(479), q16(1), 0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, q16(1), 1);
    send_point(32'hFFFF_FFFF, 32'h0000_8000, 32'h7FFF_FFFF, 0);
    send_point(q16(5) | 32'h8000, q16(7) | 32'h4000, q16(1), 1);
    drain();
    // perspective: z + 1 divides, a z of -1 gives a zero divisor
    write_reg(pwbs_pkg::CFG_R2_C01, 64'h0);
    write_reg(pwbs_pkg::CFG_R2_C23, {32'h0001_0000, 32'h0001_0000});
    write_reg(pwbs_pkg::CFG_R0_C23, {32'hFFFF_8000, 32'h0000_0000});
    write_reg(pwbs_pkg::CFG_R1_C23, {32'h0000_8000, 32'h0000_0000});
    write_reg(pwbs_pkg::CFG_WIDTH, 64'd4096);
    write_reg(pwbs_pkg::CFG_HEIGHT, 64'd4096);
    send_point(q16(100), q16(200), q16(-1), 0);
    send_point(q16(100), q16(200), q16(0), 0);
    send_point(q16(-100), q16(200), q16(1), 0);
    send_point(q16(4000), q16(4000), q16(0), 1);
    drain();
    // dimensions: oversize saturates, tiny never in bounds
    write_reg(pwbs_pkg::CFG_WIDTH, 64'h1FFF);
    write_reg(pwbs_pkg::CFG_HEIGHT, 64'd2);
    send_point(q16(4094), q16(0) | 32'h1234, q16(0), 0);
    send_point(q16(4095), q16(0), q16(0), 0);
    drain();
    write_reg(pwbs_pkg::CFG_WIDTH, 64'd1);
    send_point(q16(0), q16(0), q16(0), 0);
    drain();
    write_reg(pwbs_pkg::CFG_WIDTH, 64'd0);
    send_point(q16(0), q16(0), q16(0), 1);
    drain();
    write_reg(pwbs_pkg::CFG_R0_C01, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(pwbs_pkg::CFG_R1_C01, 64'h8000_0000_7FFF_FFFF);
    write_reg(pwbs_pkg::CFG_R2_C01, 64'h0000_0001_0000_0001);
    write_reg(pwbs_pkg::CFG_WIDTH, 64'd4096);
    write_reg(pwbs_pkg::CFG_HEIGHT, 64'd4096);
    random_points(60, 0);
    drain();
    // random matrices, mostly near-valid projections
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(pwbs_pkg::CFG_R0_C01, {q16($urandom_range(0, 2)) | $urandom_range(0, 65535),
                                       32'(ph[0] ? $urandom() : q16(1))});
      write_reg(pwbs_pkg::CFG_R0_C23, {q16($urandom_range(0, 40)),
                                       32'($urandom_range(0, 65535))});
      write_reg(pwbs_pkg::CFG_R1_C01, {32'(ph[1] ? $urandom() : q16(1)),
                                       32'($urandom_range(0, 65535))});
      write_reg(pwbs_pkg::CFG_R1_C23, {q16($urandom_range(0, 40)),
                                       32'($urandom_range(0, 65535))});
      write_reg(pwbs_pkg::CFG_R2_C01, {32'($urandom_range(0, 255)),
                                       32'($urandom_range(0, 255))});
      write_reg(pwbs_pkg::CFG_R2_C23, {q16($urandom_range(0, 1)),
                                       ph == 7 ? $urandom() : q16(1)});
      write_reg(pwbs_pkg::CFG_WIDTH, 64'($urandom_range(2, 1200)));
      write_reg(pwbs_pkg::CFG_HEIGHT, 64'($urandom_range(2, 1200)));
      random_points(55, 1);
      random_points(15, 2);
      random_points(10, 0);
      drain();
    end
    write_reg(pwbs_pkg::CFG_R0_C01, pwbs_pkg::RST_R0_C01);
    write_reg(pwbs_pkg::CFG_R0_C23, pwbs_pkg::RST_R0_C23);
    write_reg(pwbs_pkg::CFG_R1_C01, pwbs_pkg::RST_R1_C01);
    write_reg(pwbs_pkg::CFG_R1_C23, pwbs_pkg::RST_R1_C23);
    write_reg(pwbs_pkg::CFG_R2_C01, pwbs_pkg::RST_R2_C01);
    write_reg(pwbs_pkg::CFG_R2_C23, pwbs_pkg::RST_R2_C23);
    random_points(40, 1);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

/* files.f */
hw/rtl/pwbs_pkg.sv
hw/rtl/pwbs_if.sv
hw/rtl/pwbs_front.sv
hw/rtl/pwbs_queue.sv
hw/rtl/pwbs_back.sv
hw/rtl/perspective_warp_bilinear_setup_top.sv
bench/tb_perspective_warp_bilinear_setup_top.sv
